/* sv/condensed_distance_medoid_unit_macros.svh */
// Assertion macros for the condensed distance medoid unit.
// Used by the top level; depends on nothing else.
`ifndef CONDENSED_DISTANCE_MEDOID_UNIT_MACROS_SVH
`define CONDENSED_DISTANCE_MEDOID_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cdm_pkg.sv */
// Package for the condensed distance medoid unit: payload types, codes and sizes.
// Depends on nothing; imported by the top level.
`default_nettype none

package cdm_pkg;

   // Sizes of the point space, member set and number format.
   localparam int POINTS      = 64;
   localparam int MAX_MEMBERS = 64;
   localparam int FRAC_BITS   = 16;
   localparam int STORE_DEPTH = (POINTS * (POINTS - 1)) / 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PT_W        = 6;
   localparam int CNT_W       = 7;
   localparam int DIST_W      = 32;
   localparam int SUM_W       = 48;
   localparam int PROD_W      = 14;
   localparam int MEM_AW      = $clog2(MAX_MEMBERS);

   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [63:0]       START_RAW = 64'd100000000 << FRAC_BITS;
   localparam logic [SUM_W-1:0]  START_SUM =
      (START_RAW > 64'(SUM_MAX)) ? SUM_MAX : START_RAW[SUM_W-1:0];
   localparam logic [DIST_W-1:0] DIST_ONE  = DIST_W'(64'd1 << FRAC_BITS);

   // Request codes.
   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_MEMBER = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_READ      = 2'd0;
   localparam logic [1:0] KIND_MEDOID    = 2'd1;
   localparam logic [1:0] KIND_WRITE_ERR = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EQUAL = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
   localparam logic [1:0] STAT_OVER  = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [PT_W-1:0]   first_point;
      logic [PT_W-1:0]   second_point;
      logic [DIST_W-1:0] distance_in;
      logic [PT_W-1:0]   member_point;
      logic              member_last;
   } cdm_req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [1:0]        status;
      logic [DIST_W-1:0] distance_out;
      logic [PT_W-1:0]   medoid_point;
   } cdm_rsp_type;

endpackage

`default_nettype wire

/* sv/condensed_distance_medoid_unit.sv */
// Condensed distance store with medoid search over a member set.
// Depends on cdm_pkg and condensed_distance_medoid_unit_macros.svh.
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_data        taken when start is high and busy is low
//   response  rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//   csr       csr_wr_en, csr_wr_data       point_count, written when csr_wr_en is high
//
// After reset the distance store is swept to 1.0, one entry a cycle, over all 2016
// entries; busy stays high meanwhile, while csr writes are still taken.
// A failed read or write, and a member that does not end the set, are handled in
// the idle state. A good write or read runs the index multiply and the index add,
// then the store write or the registered store read. A search checks each member's
// range, then sums each member's distances to members with other points, all
// through one saturating 48-bit accumulator and one store read port.
// Each response appears in the cycle after the transaction finishes.
`default_nettype none

`include "condensed_distance_medoid_unit_macros.svh"

module condensed_distance_medoid_unit
   import cdm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire cdm_req_type  req_data,
   output logic              rsp_valid,
   output cdm_rsp_type       rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data
);

   typedef enum logic [13:0] {
      ST_CLEAR    = 14'b00000000000001,
      ST_IDLE     = 14'b00000000000010,
      ST_IDX_MUL  = 14'b00000000000100,
      ST_IDX_ADD  = 14'b00000000001000,
      ST_STORE    = 14'b00000000010000,
      ST_READ_END = 14'b00000000100000,
      ST_CHK_RD   = 14'b00000001000000,
      ST_CHK_TEST = 14'b00000010000000,
      ST_ROW_RD   = 14'b00000100000000,
      ST_ROW_LAT  = 14'b00001000000000,
      ST_COL_RD   = 14'b00010000000000,
      ST_COL_LAT  = 14'b00100000000000,
      ST_ACC      = 14'b01000000000000,
      ST_ROW_END  = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  point_count_ff, point_count_in;
   logic [CNT_W-1:0]  member_count_ff, member_count_in;
   logic [CNT_W-1:0]  search_cnt_ff, search_cnt_in;
   logic [1:0]        search_stat_ff, search_stat_in;
   logic [1:0]        op_ff, op_in;
   logic [PT_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [DIST_W-1:0] wdata_ff, wdata_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [PT_W-1:0]   mi_ff, mi_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [PT_W-1:0]   best_member_ff, best_member_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cdm_rsp_type       rsp_data_ff, rsp_data_in;

   // Memories and their registered read data.
   logic [DIST_W-1:0] store_mem [STORE_DEPTH];
   logic [DIST_W-1:0] store_rdata_ff;
   logic              store_we;
   logic [ADDR_W-1:0] store_waddr;
   logic [DIST_W-1:0] store_wdata;
   logic [PT_W-1:0]   member_mem [MAX_MEMBERS];
   logic [PT_W-1:0]   mem_rdata_ff;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_raddr;

   // Helpers for pair location and the accumulator.
   logic [PT_W-1:0]   lo_pt, hi_pt;
   logic              pair_equal, pair_range;
   logic              count_bad;
   logic              over;
   logic [CNT_W-1:0]  cnt_after;
   logic [7:0]        idx_factor;
   logic [PROD_W-1:0] addr_wide;
   logic [SUM_W:0]    sum_wide;
   logic [CNT_W-1:0]  i_next, j_next;
   logic              take;

   assign busy      = (state_ff != ST_IDLE);
   assign take      = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Order the request pair and flag its errors.
   always_comb begin
      if (req_data.first_point < req_data.second_point) begin
         lo_pt = req_data.first_point;
         hi_pt = req_data.second_point;
      end else begin
         lo_pt = req_data.second_point;
         hi_pt = req_data.first_point;
      end
      count_bad  = (point_count_ff > CNT_W'(POINTS));
      pair_equal = (req_data.first_point == req_data.second_point);
      pair_range = count_bad || ({1'b0, hi_pt} >= point_count_ff);
      over       = (member_count_ff >= CNT_W'(MAX_MEMBERS));
      cnt_after  = over ? member_count_ff : member_count_ff + CNT_W'(1);
      idx_factor = {1'b0, point_count_ff} + {1'b0, point_count_ff} - 8'd3 - {2'b00, a_ff};
      addr_wide  = (prod_ff >> 1) + PROD_W'(b_ff) - PROD_W'(1);
      sum_wide   = {1'b0, sum_ff} + (SUM_W+1)'(store_rdata_ff);
      i_next     = i_ff + CNT_W'(1);
      j_next     = j_ff + CNT_W'(1);
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in        = state_ff;
      point_count_in  = csr_wr_en ? csr_wr_data : point_count_ff;
      member_count_in = member_count_ff;
      search_cnt_in   = search_cnt_ff;
      search_stat_in  = search_stat_ff;
      op_in           = op_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      wdata_in        = wdata_ff;
      prod_in         = prod_ff;
      addr_in         = addr_ff;
      clr_addr_in     = clr_addr_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      mi_in           = mi_ff;
      sum_in          = sum_ff;
      best_sum_in     = best_sum_ff;
      best_member_in  = best_member_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = rsp_data_ff;
      store_we        = 1'b0;
      store_waddr     = addr_ff;
      store_wdata     = wdata_ff;
      mem_we          = 1'b0;
      mem_raddr       = i_ff[MEM_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            store_we    = 1'b1;
            store_waddr = clr_addr_ff;
            store_wdata = DIST_ONE;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               op_in    = req_data.req_type;
               a_in     = lo_pt;
               b_in     = hi_pt;
               wdata_in = req_data.distance_in;
               case (req_data.req_type)
                  REQ_WRITE, REQ_READ: begin
                     if (pair_equal || pair_range) begin
                        rsp_valid_in             = 1'b1;
                        rsp_data_in.result_kind  = (req_data.req_type == REQ_WRITE) ?
                                                   KIND_WRITE_ERR : KIND_READ;
                        rsp_data_in.status       = pair_equal ? STAT_EQUAL : STAT_RANGE;
                        rsp_data_in.distance_out = '0;
                        rsp_data_in.medoid_point = '0;
                     end else begin
                        state_in = ST_IDX_MUL;
                     end
                  end
                  REQ_MEMBER: begin
                     mem_we          = !over;
                     member_count_in = cnt_after;
                     if (!req_data.member_last) begin
                        if (over) begin
                           rsp_valid_in             = 1'b1;
                           rsp_data_in.result_kind  = KIND_MEDOID;
                           rsp_data_in.status       = STAT_OVER;
                           rsp_data_in.distance_out = '0;
                           rsp_data_in.medoid_point = '0;
                        end
                     end else begin
                        member_count_in = '0;
                        search_cnt_in   = cnt_after;
                        search_stat_in  = over ? STAT_OVER : STAT_OK;
                        i_in            = '0;
                        if (count_bad) begin
                           rsp_valid_in             = 1'b1;
                           rsp_data_in.result_kind  = KIND_MEDOID;
                           rsp_data_in.status       = STAT_RANGE;
                           rsp_data_in.distance_out = '0;
                           rsp_data_in.medoid_point = '0;
                        end else begin
                           state_in = ST_CHK_RD;
                        end
                     end
                  end
                  default: begin
                     // An unknown request is dropped.
                  end
               endcase
            end
         end
         // Shared index unit: multiply, then add.
         ST_IDX_MUL: begin
            prod_in  = PROD_W'(idx_factor * a_ff);
            state_in = ST_IDX_ADD;
         end
         ST_IDX_ADD: begin
            addr_in  = addr_wide[ADDR_W-1:0];
            state_in = ST_STORE;
         end
         ST_STORE: begin
            case (op_ff)
               REQ_WRITE: begin
                  store_we = 1'b1;
                  state_in = ST_IDLE;
               end
               REQ_READ: state_in = ST_READ_END;
               default:  state_in = ST_ACC;
            endcase
         end
         ST_READ_END: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = KIND_READ;
            rsp_data_in.status       = STAT_OK;
            rsp_data_in.distance_out = store_rdata_ff;
            rsp_data_in.medoid_point = '0;
            state_in                 = ST_IDLE;
         end
         // Range check over the held members.
         ST_CHK_RD: begin
            mem_raddr = i_ff[MEM_AW-1:0];
            state_in  = ST_CHK_TEST;
         end
         ST_CHK_TEST: begin
            if ({1'b0, mem_rdata_ff} >= point_count_ff) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_kind  = KIND_MEDOID;
               rsp_data_in.status       = STAT_RANGE;
               rsp_data_in.distance_out = '0;
               rsp_data_in.medoid_point = '0;
               state_in                 = ST_IDLE;
            end else if (i_next == search_cnt_ff) begin
               i_in        = '0;
               best_sum_in = START_SUM;
               state_in    = ST_ROW_RD;
            end else begin
               i_in     = i_next;
               state_in = ST_CHK_RD;
            end
         end
         // Row loop: fetch member i and clear its sum.
         ST_ROW_RD: begin
            mem_raddr = i_ff[MEM_AW-1:0];
            state_in  = ST_ROW_LAT;
         end
         ST_ROW_LAT: begin
            mi_in  = mem_rdata_ff;
            sum_in = '0;
            j_in   = '0;
            if (i_ff == '0) begin
               best_member_in = mem_rdata_ff;
            end
            state_in = ST_COL_RD;
         end
         // Column loop: fetch member j and locate the pair.
         ST_COL_RD: begin
            mem_raddr = j_ff[MEM_AW-1:0];
            state_in  = ST_COL_LAT;
         end
         ST_COL_LAT: begin
            if (mem_rdata_ff == mi_ff) begin
               j_in     = j_next;
               state_in = (j_next == search_cnt_ff) ? ST_ROW_END : ST_COL_RD;
            end else begin
               a_in     = (mi_ff < mem_rdata_ff) ? mi_ff : mem_rdata_ff;
               b_in     = (mi_ff < mem_rdata_ff) ? mem_rdata_ff : mi_ff;
               state_in = ST_IDX_MUL;
            end
         end
         // Saturating accumulate of one distance.
         ST_ACC: begin
            sum_in   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            j_in     = j_next;
            state_in = (j_next == search_cnt_ff) ? ST_ROW_END : ST_COL_RD;
         end
         ST_ROW_END: begin
            if (sum_ff < best_sum_ff) begin
               best_sum_in    = sum_ff;
               best_member_in = mi_ff;
            end
            if (i_next == search_cnt_ff) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_kind  = KIND_MEDOID;
               rsp_data_in.status       = search_stat_ff;
               rsp_data_in.distance_out = '0;
               rsp_data_in.medoid_point = (sum_ff < best_sum_ff) ? mi_ff : best_member_ff;
               state_in                 = ST_IDLE;
            end else begin
               i_in     = i_next;
               state_in = ST_ROW_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         point_count_ff  <= CNT_W'(POINTS);
         member_count_ff <= '0;
         clr_addr_ff     <= '0;
         best_sum_ff     <= START_SUM;
         best_member_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         point_count_ff  <= point_count_in;
         member_count_ff <= member_count_in;
         clr_addr_ff     <= clr_addr_in;
         best_sum_ff     <= best_sum_in;
         best_member_ff  <= best_member_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      search_cnt_ff  <= search_cnt_in;
      search_stat_ff <= search_stat_in;
      op_ff          <= op_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      wdata_ff       <= wdata_in;
      prod_ff        <= prod_in;
      addr_ff        <= addr_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      mi_ff          <= mi_in;
      sum_ff         <= sum_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Distance store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      store_rdata_ff <= store_mem[addr_ff];
   end

   // Member list: written at the fill count, read by the sequencer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         member_mem[member_count_ff[MEM_AW-1:0]] <= req_data.member_point;
      end
      mem_rdata_ff <= member_mem[mem_raddr];
   end

   // Checks on the sequencer and the store ports.
   `CDM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, member_count_ff <= CNT_W'(MAX_MEMBERS), "member count exceeds the set size")
   `CDM_ASSERT_NOW(a_store_addr, clock, reset, store_we, store_waddr < ADDR_W'(STORE_DEPTH), "store write address out of range")
   `CDM_ASSERT_NOW(a_col_bound, clock, reset, state_ff == ST_COL_RD || state_ff == ST_COL_LAT, j_ff < search_cnt_ff, "column index past member count")
   `CDM_ASSERT_NEXT(a_clear_busy, clock, reset, state_ff == ST_CLEAR && clr_addr_ff != ADDR_W'(STORE_DEPTH - 1), busy && !rsp_valid, "activity during the clearing sweep")

endmodule

`default_nettype wire
